>>> rtl/dpc_pkg.sv
// ----------------------------------------------------------------------------
// dpc_pkg: shared types and constants of the debounced pulse counter
// Field widths, configuration register indexes, reset values and the
// structs that travel between the counter submodules.
// ----------------------------------------------------------------------------
package dpc_pkg;

    // Default parameter values
    localparam int COUNT_BITS_DEF = 32;
    localparam int TIMER_BITS_DEF = 16;

    // Field widths
    localparam int TICKS_W   = 16;
    localparam int SCALE_W   = 32;
    localparam int PCOUNT_W  = 32;
    localparam int SCALED_W  = 48;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd5;

    // Register reset values
    localparam logic [TICKS_W-1:0] RST_MIN_WIDTH  = 16'd10;
    localparam logic [TICKS_W-1:0] RST_PERIOD     = 16'd100;
    localparam logic               RST_FAST_MODE  = 1'b0;
    localparam logic               RST_ENABLE     = 1'b1;
    localparam logic               RST_ACTIVE_LOW = 1'b0;
    localparam logic [SCALE_W-1:0] RST_SCALE      = 32'd65536;

    // Holdoff used when the period does not exceed the width
    localparam logic [TICKS_W-1:0] HOLDOFF_FALLBACK = 16'd10;

    // Configuration register set
    typedef struct packed {
        logic [TICKS_W-1:0] min_width;
        logic [TICKS_W-1:0] period;
        logic               fast_mode;
        logic               enabled;
        logic               active_low;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

    // Pipeline advance strobes for the scaling stages
    typedef struct packed {
        logic adv_mul;
        logic adv_out;
    } t_pipe_ctl;

endpackage

>>> rtl/dpc_if.sv
// ----------------------------------------------------------------------------
// dpc_if: channel interfaces of the debounced pulse counter
// Tick input stream, result output stream and configuration write channel,
// each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dpc_in_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic clear_count;

    modport source (output valid, output pin_level, output clear_count, input ready);
    modport sink   (input valid, input pin_level, input clear_count, output ready);
endinterface

interface dpc_out_if;
    logic                          valid;
    logic                          ready;
    logic [dpc_pkg::PCOUNT_W-1:0]  pulse_count;
    logic [dpc_pkg::SCALED_W-1:0]  scaled_count;
    logic                          pulse_counted;

    modport source (output valid, output pulse_count, output scaled_count,
                    output pulse_counted, input ready);
    modport sink   (input valid, input pulse_count, input scaled_count,
                    input pulse_counted, output ready);
endinterface

interface dpc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dpc_pkg::CFG_IDX_W-1:0] index;
    logic [dpc_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/dpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dpc_cfg_regs: configuration register file
// Decodes write transactions on the configuration channel into the
// register set; writes to unknown indexes are accepted and dropped.
// ----------------------------------------------------------------------------
module dpc_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dpc_cfg_if.sink        i_cfg,
    output dpc_pkg::t_cfg  o_cfg
);

    dpc_pkg::t_cfg r_cfg;
    dpc_pkg::t_cfg n_cfg;

    // Always ready for a write
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                dpc_pkg::REG_MIN_WIDTH:  n_cfg.min_width  = i_cfg.data[dpc_pkg::TICKS_W-1:0];
                dpc_pkg::REG_PERIOD:     n_cfg.period     = i_cfg.data[dpc_pkg::TICKS_W-1:0];
                dpc_pkg::REG_FAST_MODE:  n_cfg.fast_mode  = i_cfg.data[0];
                dpc_pkg::REG_ENABLE:     n_cfg.enabled    = i_cfg.data[0];
                dpc_pkg::REG_ACTIVE_LOW: n_cfg.active_low = i_cfg.data[0];
                dpc_pkg::REG_SCALE:      n_cfg.scale      = i_cfg.data[dpc_pkg::SCALE_W-1:0];
                default:                 n_cfg            = r_cfg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_width  <= dpc_pkg::RST_MIN_WIDTH;
            r_cfg.period     <= dpc_pkg::RST_PERIOD;
            r_cfg.fast_mode  <= dpc_pkg::RST_FAST_MODE;
            r_cfg.enabled    <= dpc_pkg::RST_ENABLE;
            r_cfg.active_low <= dpc_pkg::RST_ACTIVE_LOW;
            r_cfg.scale      <= dpc_pkg::RST_SCALE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

>>> rtl/dpc_channel.sv
// ----------------------------------------------------------------------------
// dpc_channel: edge detect, width wait, holdoff and pulse count
// Updates the channel state once per accepted tick and holds the new count
// and the counted flag as the first pipeline stage.
// ----------------------------------------------------------------------------
module dpc_channel #(
    parameter int COUNT_BITS = dpc_pkg::COUNT_BITS_DEF,
    parameter int TIMER_BITS = dpc_pkg::TIMER_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dpc_pkg::t_cfg         i_cfg,
    input  logic                  i_accept,
    input  logic                  i_pin_level,
    input  logic                  i_clear_count,
    output logic [COUNT_BITS-1:0] o_count,
    output logic                  o_counted
);

    typedef enum logic [1:0] {
        PH_ARMED,
        PH_WIDTH,
        PH_HOLD
    } t_phase;

    localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

    t_phase                r_phase,   n_phase;
    logic [TIMER_BITS-1:0] r_timer,   n_timer;
    logic [COUNT_BITS-1:0] r_count,   n_count;
    logic                  r_prev,    n_prev;
    logic                  r_counted, n_counted;

    logic                        w_act;
    logic                        w_edge;
    logic [TIMER_BITS-1:0]       w_dec;
    logic [dpc_pkg::TICKS_W-1:0] w_eff_width;
    logic [dpc_pkg::TICKS_W-1:0] w_holdoff;

    // Clamp a tick count to what the timer holds
    function automatic logic [TIMER_BITS-1:0] sat_timer(input logic [dpc_pkg::TICKS_W-1:0] v);
        logic [32:0] ext;
        ext = 33'(v);
        if (ext > TIMER_MAX) begin
            return TIMER_MAX[TIMER_BITS-1:0];
        end
        return TIMER_BITS'(v);
    endfunction

    // Active level, edge and wait lengths
    always_comb begin
        w_act       = ~i_cfg.active_low;
        w_edge      = (i_pin_level != r_prev) && (i_pin_level == w_act) && i_cfg.enabled;
        w_dec       = r_timer - TIMER_BITS'(1);
        w_eff_width = (i_cfg.min_width == '0) ? dpc_pkg::TICKS_W'(1) : i_cfg.min_width;
        w_holdoff   = (i_cfg.period > w_eff_width) ? (i_cfg.period - w_eff_width)
                                                   : dpc_pkg::HOLDOFF_FALLBACK;
    end

    // Next state for one tick
    always_comb begin
        n_count   = i_clear_count ? '0 : r_count;
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_counted = 1'b0;
        n_prev    = i_pin_level;
        if (i_cfg.fast_mode) begin
            n_phase = PH_ARMED;
            n_timer = '0;
            if (w_edge) begin
                n_count   = n_count + COUNT_BITS'(1);
                n_counted = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_WIDTH: begin
                    n_timer = w_dec;
                    if (w_dec == '0) begin
                        if (i_pin_level == w_act) begin
                            n_count   = n_count + COUNT_BITS'(1);
                            n_counted = 1'b1;
                            n_phase   = PH_HOLD;
                            n_timer   = sat_timer(w_holdoff);
                        end else begin
                            n_phase = PH_ARMED;
                        end
                    end
                end
                PH_HOLD: begin
                    n_timer = w_dec;
                    if (w_dec == '0) begin
                        n_phase = PH_ARMED;
                    end
                end
                default: begin
                    n_phase = PH_ARMED;
                    if (w_edge) begin
                        n_phase = PH_WIDTH;
                        n_timer = sat_timer(w_eff_width);
                    end
                end
            endcase
        end
    end

    // Advance state on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_ARMED;
            r_timer   <= '0;
            r_count   <= '0;
            r_prev    <= 1'b0;
            r_counted <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_count   <= n_count;
            r_prev    <= n_prev;
            r_counted <= n_counted;
        end
    end

    assign o_count   = r_count;
    assign o_counted = r_counted;

endmodule

>>> rtl/dpc_scale.sv
// ----------------------------------------------------------------------------
// dpc_scale: Q16.16 scaling of the pulse count
// Splits the count at bit 16, forms both partial products in one stage and
// adds them into the result register in the next.
// ----------------------------------------------------------------------------
module dpc_scale #(
    parameter int COUNT_BITS = dpc_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  dpc_pkg::t_pipe_ctl            i_ctl,
    input  logic [dpc_pkg::SCALE_W-1:0]   i_scale,
    input  logic [COUNT_BITS-1:0]         i_count,
    input  logic                          i_counted,
    output logic [dpc_pkg::PCOUNT_W-1:0]  o_pulse_count,
    output logic [dpc_pkg::SCALED_W-1:0]  o_scaled_count,
    output logic                          o_pulse_counted
);

    localparam int W = dpc_pkg::SCALED_W;

    logic [W-1:0]  w_ext;
    logic [31:0]   w_hi;
    logic [15:0]   w_lo;
    logic [W-1:0]  w_hi_prod;
    logic [W-1:0]  w_lo_prod;

    logic [W-1:0]                 r_hi_prod;
    logic [31:0]                  r_lo_part;
    logic [dpc_pkg::PCOUNT_W-1:0] r_mul_count;
    logic                         r_mul_counted;

    logic [dpc_pkg::PCOUNT_W-1:0] r_out_count;
    logic [W-1:0]                 r_out_scaled;
    logic                         r_out_counted;

    // Partial products of the split count
    always_comb begin
        w_ext     = W'(i_count);
        w_hi      = w_ext[W-1:16];
        w_lo      = w_ext[15:0];
        w_hi_prod = W'(w_hi) * W'(i_scale);
        w_lo_prod = W'(w_lo) * W'(i_scale);
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_mul) begin
            r_hi_prod     <= w_hi_prod;
            r_lo_part     <= w_lo_prod[W-1:16];
            r_mul_count   <= w_ext[dpc_pkg::PCOUNT_W-1:0];
            r_mul_counted <= i_counted;
        end
    end

    // Sum into the result register
    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_out) begin
            r_out_scaled  <= r_hi_prod + W'(r_lo_part);
            r_out_count   <= r_mul_count;
            r_out_counted <= r_mul_counted;
        end
    end

    assign o_pulse_count   = r_out_count;
    assign o_scaled_count  = r_out_scaled;
    assign o_pulse_counted = r_out_counted;

endmodule

>>> rtl/debounced_pulse_counter.sv
// ----------------------------------------------------------------------------
// debounced_pulse_counter: pulse counter channel with width debounce
// One tick per input transaction; one result transaction per tick.
// ----------------------------------------------------------------------------
// The block takes one tick transaction every clock cycle while the output
// is not stalled, and returns one result for each tick. The channel state
// (edge detect, width wait, holdoff, count) is updated in a single pass as
// each tick is accepted; the Q16.16 scaling of the count runs behind it as a
// multiply stage and an add stage that feed the output register. Stalls on
// the output propagate back stage by stage, and any empty stage lets a new
// tick in. Configuration writes are taken every cycle and must only be
// issued while no tick is in flight.
module debounced_pulse_counter #(
    parameter int COUNT_BITS = dpc_pkg::COUNT_BITS_DEF,
    parameter int TIMER_BITS = dpc_pkg::TIMER_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpc_cfg_if.sink    i_cfg,
    dpc_in_if.sink     i_in,
    dpc_out_if.source  o_out
);

    dpc_pkg::t_cfg      w_cfg;
    dpc_pkg::t_pipe_ctl w_ctl;

    logic                  r_s1_v;
    logic                  r_s2_v;
    logic                  r_out_v;
    logic                  w_adv_s1;
    logic                  w_accept;
    logic [COUNT_BITS-1:0] w_count;
    logic                  w_counted;

    // Stage advance: a stage moves when it is empty or its successor moves
    always_comb begin
        w_ctl.adv_out = !r_out_v || o_out.ready;
        w_ctl.adv_mul = !r_s2_v || w_ctl.adv_out;
        w_adv_s1      = !r_s1_v || w_ctl.adv_mul;
        w_accept      = i_in.valid && w_adv_s1;
    end

    assign i_in.ready  = w_adv_s1;
    assign o_out.valid = r_out_v;

    // Track stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_adv_s1) begin
                r_s1_v <= i_in.valid;
            end
            if (w_ctl.adv_mul) begin
                r_s2_v <= r_s1_v;
            end
            if (w_ctl.adv_out) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    dpc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    dpc_channel #(
        .COUNT_BITS (COUNT_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_channel (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_accept      (w_accept),
        .i_pin_level   (i_in.pin_level),
        .i_clear_count (i_in.clear_count),
        .o_count       (w_count),
        .o_counted     (w_counted)
    );

    dpc_scale #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scale (
        .i_clk           (i_clk),
        .i_ctl           (w_ctl),
        .i_scale         (w_cfg.scale),
        .i_count         (w_count),
        .i_counted       (w_counted),
        .o_pulse_count   (o_out.pulse_count),
        .o_scaled_count  (o_out.scaled_count),
        .o_pulse_counted (o_out.pulse_counted)
    );

endmodule

>>> test/dpc_checker.sv
// ----------------------------------------------------------------------------
// dpc_checker: scoreboard for the debounced pulse counter
// Watches the configuration, tick and result channels. Keeps its own copy of
// the channel state and register set, works out the result of every accepted
// tick, and compares each accepted result field by field with the oldest one.
// ----------------------------------------------------------------------------
module dpc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    dpc_cfg_if   i_cfg,
    dpc_in_if    i_in,
    dpc_out_if   i_out,
    output int   o_mismatches,
    output int   o_pending
);

    typedef enum logic [1:0] {
        CH_ARMED      = 2'd0,
        CH_WIDTH_WAIT = 2'd1,
        CH_HOLDOFF    = 2'd2
    } t_channel_phase;

    typedef struct packed {
        logic [dpc_pkg::PCOUNT_W-1:0] pulse_count;
        logic [dpc_pkg::SCALED_W-1:0] scaled_count;
        logic                         pulse_counted;
    } t_tick_result;

    // Shadow register set and channel state
    dpc_pkg::t_cfg                      settings;
    logic                               prev_pin;
    t_channel_phase                     ch_phase;
    logic [dpc_pkg::TIMER_BITS_DEF-1:0] wait_timer;
    logic [dpc_pkg::COUNT_BITS_DEF-1:0] pulse_total;

    t_tick_result expected_results[$];
    int           mismatch_count;
    int           result_index;

    assign o_mismatches = mismatch_count;

    // Width of the holdoff that follows a counted pulse
    function automatic logic [dpc_pkg::TIMER_BITS_DEF-1:0] holdoff_ticks();
        logic [dpc_pkg::TICKS_W-1:0] width_eff;
        width_eff = (settings.min_width == '0) ? dpc_pkg::TICKS_W'(1) : settings.min_width;
        if (settings.period > width_eff)
            return settings.period - width_eff;
        return dpc_pkg::HOLDOFF_FALLBACK;
    endfunction

    // Advance the channel by one tick and return the result it produces
    function automatic t_tick_result count_tick(input logic pin, input logic clr);
        t_tick_result res;
        logic         act_level;
        logic         active_edge;
        logic         counted;
        logic [63:0]  product;
        act_level   = settings.active_low ? 1'b0 : 1'b1;
        active_edge = (pin != prev_pin) && (pin == act_level) && settings.enabled;
        counted     = 1'b0;

        if (clr)
            pulse_total = '0;

        if (settings.fast_mode) begin
            ch_phase   = CH_ARMED;
            wait_timer = '0;
            if (active_edge) begin
                pulse_total = pulse_total + 1'b1;
                counted     = 1'b1;
            end
        end else begin
            case (ch_phase)
                CH_WIDTH_WAIT: begin
                    wait_timer = wait_timer - 1'b1;
                    if (wait_timer == '0) begin
                        if (pin == act_level) begin
                            pulse_total = pulse_total + 1'b1;
                            counted     = 1'b1;
                            ch_phase    = CH_HOLDOFF;
                            wait_timer  = holdoff_ticks();
                        end else begin
                            ch_phase = CH_ARMED;
                        end
                    end
                end
                CH_HOLDOFF: begin
                    wait_timer = wait_timer - 1'b1;
                    if (wait_timer == '0)
                        ch_phase = CH_ARMED;
                end
                default: begin
                    ch_phase = CH_ARMED;
                    if (active_edge) begin
                        ch_phase   = CH_WIDTH_WAIT;
                        wait_timer = (settings.min_width == '0) ?
                                     dpc_pkg::TIMER_BITS_DEF'(1) : settings.min_width;
                    end
                end
            endcase
        end

        prev_pin = pin;

        product           = 64'(pulse_total) * 64'(settings.scale);
        res.pulse_count   = pulse_total[dpc_pkg::PCOUNT_W-1:0];
        res.scaled_count  = product[63:16];
        res.pulse_counted = counted;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("result %0d: %s got 0x%0h, want 0x%0h", result_index, what, got, want);
        mismatch_count++;
    endtask

    // Track writes, predict on each tick transaction, compare on each result
    always @(posedge i_clk) begin
        t_tick_result want;
        t_tick_result got;
        if (!i_rst_n) begin
            settings.min_width  = dpc_pkg::RST_MIN_WIDTH;
            settings.period     = dpc_pkg::RST_PERIOD;
            settings.fast_mode  = dpc_pkg::RST_FAST_MODE;
            settings.enabled    = dpc_pkg::RST_ENABLE;
            settings.active_low = dpc_pkg::RST_ACTIVE_LOW;
            settings.scale      = dpc_pkg::RST_SCALE;
            prev_pin    = 1'b0;
            ch_phase    = CH_ARMED;
            wait_timer  = '0;
            pulse_total = '0;
            expected_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    dpc_pkg::REG_MIN_WIDTH:
                        settings.min_width = i_cfg.data[dpc_pkg::TICKS_W-1:0];
                    dpc_pkg::REG_PERIOD:
                        settings.period = i_cfg.data[dpc_pkg::TICKS_W-1:0];
                    dpc_pkg::REG_FAST_MODE:  settings.fast_mode  = i_cfg.data[0];
                    dpc_pkg::REG_ENABLE:     settings.enabled    = i_cfg.data[0];
                    dpc_pkg::REG_ACTIVE_LOW: settings.active_low = i_cfg.data[0];
                    dpc_pkg::REG_SCALE:
                        settings.scale = i_cfg.data[dpc_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end

            if (i_in.valid && i_in.ready)
                expected_results.push_back(count_tick(i_in.pin_level, i_in.clear_count));

            if (i_out.valid && i_out.ready) begin
                got.pulse_count   = i_out.pulse_count;
                got.scaled_count  = i_out.scaled_count;
                got.pulse_counted = i_out.pulse_counted;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, pulse_count", 64'(got.pulse_count),
                                    64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.pulse_count !== want.pulse_count)
                        report_mismatch("pulse_count", 64'(got.pulse_count),
                                        64'(want.pulse_count));
                    if (got.scaled_count !== want.scaled_count)
                        report_mismatch("scaled_count", 64'(got.scaled_count),
                                        64'(want.scaled_count));
                    if (got.pulse_counted !== want.pulse_counted)
                        report_mismatch("pulse_counted", 64'(got.pulse_counted),
                                        64'(want.pulse_counted));
                end
                result_index++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the debounced pulse counter
// Drives a short directed run at the reset settings and in fast mode,
// then pulse trains with random content under several register settings,
// including the width, period and scale extremes. Both handshake sides idle
// at random. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;

    logic i_clk;
    logic i_rst_n;

    dpc_cfg_if cfg_ch ();
    dpc_in_if  tick_ch ();
    dpc_out_if result_ch ();

    int mismatches;
    int pending;
    int idle_pct;
    int idle_cycles;

    // Settings as last written, used to shape the pulse trains
    logic [dpc_pkg::TICKS_W-1:0] cur_width;
    logic [dpc_pkg::TICKS_W-1:0] cur_period;
    logic                        cur_active_low;

    debounced_pulse_counter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (tick_ch),
        .o_out   (result_ch)
    );

    dpc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_ch),
        .i_in         (tick_ch),
        .i_out        (result_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        result_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // End the run when no transaction has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((tick_ch.valid && tick_ch.ready) || (result_ch.valid && result_ch.ready)
                     || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic logic random_clear();
        return ($urandom_range(0, 15) == 0);
    endfunction

    // Send one tick; entered and left at a falling edge
    task automatic send_tick(input logic pin, input logic clr);
        if ($urandom_range(0, 99) < idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_ch.valid       <= 1'b1;
        tick_ch.pin_level   <= pin;
        tick_ch.clear_count <= clr;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold off ticks until every result is back
    task automatic drain_results();
        tick_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [dpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dpc_pkg::CFG_DAT_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input logic [dpc_pkg::TICKS_W-1:0] width,
                                  input logic [dpc_pkg::TICKS_W-1:0] period,
                                  input logic fm, input logic en, input logic al,
                                  input logic [dpc_pkg::SCALE_W-1:0] scale);
        drain_results();
        write_reg(dpc_pkg::REG_MIN_WIDTH,  dpc_pkg::CFG_DAT_W'(width));
        write_reg(dpc_pkg::REG_PERIOD,     dpc_pkg::CFG_DAT_W'(period));
        write_reg(dpc_pkg::REG_FAST_MODE,  dpc_pkg::CFG_DAT_W'(fm));
        write_reg(dpc_pkg::REG_ENABLE,     dpc_pkg::CFG_DAT_W'(en));
        write_reg(dpc_pkg::REG_ACTIVE_LOW, dpc_pkg::CFG_DAT_W'(al));
        write_reg(dpc_pkg::REG_SCALE,      dpc_pkg::CFG_DAT_W'(scale));
        cfg_ch.valid   <= 1'b0;
        cur_width      = width;
        cur_period     = period;
        cur_active_low = al;
    endtask

    // Mostly pulses around the debounce width, some raw pin noise
    task automatic drive_pulse_traffic(input int n_items);
        int   sent;
        int   run_len;
        int   width_eff;
        logic act;
        sent      = 0;
        width_eff = (cur_width == 0) ? 1 : int'(cur_width);
        act       = ~cur_active_low;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 3))
                    0:       run_len = (width_eff > 1) ? width_eff - 1 : 1;
                    1:       run_len = width_eff;
                    2:       run_len = width_eff + 1;
                    default: run_len = $urandom_range(1, width_eff + 4);
                endcase
                repeat (run_len) begin
                    send_tick(act, random_clear());
                    sent++;
                end
                if ($urandom_range(0, 3) == 0)
                    run_len = (int'(cur_period) + 3 > 40) ? 40 : int'(cur_period) + 3;
                else
                    run_len = $urandom_range(1, 12);
                repeat (run_len) begin
                    send_tick(~act, random_clear());
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_tick(1'($urandom_range(0, 1)), random_clear());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        tick_ch.valid       = 1'b0;
        tick_ch.pin_level   = 1'b0;
        tick_ch.clear_count = 1'b0;
        idle_pct            = 12;
        cur_width           = dpc_pkg::RST_MIN_WIDTH;
        cur_period          = dpc_pkg::RST_PERIOD;
        cur_active_low      = dpc_pkg::RST_ACTIVE_LOW;
        i_rst_n             = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: clear at zero, one full-width pulse, an edge lost in holdoff
        send_tick(1'b0, 1'b1);
        repeat (11) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        // Fast mode, active low, largest scale: holdoff dropped, clear on an edge
        apply_settings(16'd2, 16'd2, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        // Shortest width and period
        apply_settings(16'd1, 16'd2, 1'b0, 1'b1, 1'b0, $urandom);
        drive_pulse_traffic(35);

        // Period equal to width falls back to the fixed holdoff
        apply_settings(16'd3, 16'd3, 1'b0, 1'b1, 1'b1, $urandom);
        drive_pulse_traffic(35);

        // Zero width and zero period
        apply_settings(16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
        drive_pulse_traffic(35);

        // Fast mode with no idling on either side
        apply_settings(16'd5, 16'd20, 1'b1, 1'b1, 1'b1, $urandom);
        idle_pct = 0;
        drive_pulse_traffic(80);
        idle_pct = 12;

        // Start a width wait, then disable the channel while it runs
        apply_settings(16'd6, 16'd12, 1'b0, 1'b1, 1'b0, $urandom);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        apply_settings(16'd6, 16'd12, 1'b0, 1'b0, 1'b0, $urandom);
        drive_pulse_traffic(35);

        // Largest width and period with zero scale: start a long wait, drop it in fast mode
        apply_settings(16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 32'd0);
        send_tick(1'b0, 1'b0);
        repeat (20) send_tick(1'b1, random_clear());
        apply_settings(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 32'd0);
        repeat (4) send_tick(1'($urandom_range(0, 1)), 1'b0);

        // Random settings
        repeat (5) begin
            apply_settings(16'($urandom_range(1, 8)), 16'($urandom_range(0, 20)),
                           ($urandom_range(0, 3) == 0), ($urandom_range(0, 7) != 0),
                           1'($urandom_range(0, 1)), $urandom);
            drive_pulse_traffic(35);
        end

        // Back to the reset values
        apply_settings(dpc_pkg::RST_MIN_WIDTH, dpc_pkg::RST_PERIOD, dpc_pkg::RST_FAST_MODE,
                       dpc_pkg::RST_ENABLE, dpc_pkg::RST_ACTIVE_LOW, dpc_pkg::RST_SCALE);
        drive_pulse_traffic(35);

        drain_results();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
rtl/dpc_pkg.sv
rtl/dpc_if.sv
rtl/dpc_cfg_regs.sv
rtl/dpc_channel.sv
rtl/dpc_scale.sv
rtl/debounced_pulse_counter.sv
test/dpc_checker.sv
test/testbench.sv
